[rtl/periodic_timer_table_top_macros.svh]
// assertion macros for the checker file
`ifndef PERIODIC_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TIMER_TABLE_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PTT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in the cycle after its trigger
`define PTT_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

[rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types, constants and time arithmetic for the periodic timer table
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int unsigned TimerCount = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned MaskW      = 16;
  localparam int unsigned SecW       = 64;
  localparam int unsigned NsW        = 30;

  localparam logic [NsW-1:0]  NsPerSec = 30'd1000000000;
  localparam logic [NsW-1:0]  NsMax    = 30'd999999999;
  localparam logic [SecW-1:0] SecMax   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [SecW-1:0] SecMin   = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RETIME = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  typedef struct packed {
    logic [SecW-1:0] s;
    logic [NsW-1:0]  ns;
  } ts_t;

  // command from the sequencer that walks through the cell row
  typedef struct packed {
    logic             wr;     // add or retime write at slot
    logic             clr;    // remove at slot
    logic             step;   // shift row by one cell
    logic [SlotW-1:0] slot;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

  function automatic logic [NsW-1:0] clamp_ns(input logic [NsW-1:0] v);
    clamp_ns = (v > NsMax) ? NsMax : v;
  endfunction

  // saturating sum, nanoseconds carry at one second
  function automatic ts_t ts_add(input ts_t a, input ts_t b);
    logic [NsW:0]    ns;
    logic            cy;
    logic [SecW+1:0] sum;
    ts_t             r;
    ns  = {1'b0, a.ns} + {1'b0, b.ns};
    cy  = (ns >= {1'b0, NsPerSec});
    sum = {{2{a.s[SecW-1]}}, a.s} + {{2{b.s[SecW-1]}}, b.s} + {{(SecW+1){1'b0}}, cy};
    r.ns = cy ? NsW'(ns - {1'b0, NsPerSec}) : ns[NsW-1:0];
    r.s  = sum[SecW-1:0];
    if (!sum[SecW+1] && sum[SecW:SecW-1] != 2'b00) begin
      r.s = SecMax; r.ns = NsMax;
    end else if (sum[SecW+1] && sum[SecW:SecW-1] != 2'b11) begin
      r.s = SecMin; r.ns = '0;
    end
    ts_add = r;
  endfunction

  // saturating difference, nanoseconds borrow
  function automatic ts_t ts_sub(input ts_t a, input ts_t b);
    logic            bw;
    logic [SecW+1:0] dif;
    ts_t             r;
    bw  = (a.ns < b.ns);
    dif = {{2{a.s[SecW-1]}}, a.s} - {{2{b.s[SecW-1]}}, b.s} - {{(SecW+1){1'b0}}, bw};
    r.ns = bw ? NsW'(a.ns + NsPerSec - b.ns) : NsW'(a.ns - b.ns);
    r.s  = dif[SecW-1:0];
    if (!dif[SecW+1] && dif[SecW:SecW-1] != 2'b00) begin
      r.s = SecMax; r.ns = NsMax;
    end else if (dif[SecW+1] && dif[SecW:SecW-1] != 2'b11) begin
      r.s = SecMin; r.ns = '0;
    end
    ts_sub = r;
  endfunction

  // signed a < b
  function automatic logic ts_lt(input ts_t a, input ts_t b);
    if (a.s != b.s) ts_lt = ($signed(a.s) < $signed(b.s));
    else            ts_lt = (a.ns < b.ns);
  endfunction

endpackage

`default_nettype wire

[rtl/periodic_timer_table_top.sv]
// ----------------------------------------------------------------------------
// periodic_timer_table_top
// sixteen periodic timers in a rotating row of cells
// ----------------------------------------------------------------------------
// add, remove, retime: entry written at the accept edge, result offered next cycle
// check: the row rotates once through the head unit in ST_RUN, and the result is
// offered in ST_OUT once the rotation is done
// one transaction in flight; the next is accepted the cycle after the result is
// taken
// reset clears all valid bits and the control state; entries need no clearing
`default_nettype none

module periodic_timer_table_top
  import ptt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [SlotW-1:0]  slot_i,
  input  wire logic [SecW-1:0]   delay_sec_i,
  input  wire logic [NsW-1:0]    delay_nsec_i,
  input  wire logic [SecW-1:0]   now_sec_i,
  input  wire logic [NsW-1:0]    now_nsec_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [MaskW-1:0]       fired_mask_o,
  output logic [SecW-1:0]        wait_sec_o,
  output logic [NsW-1:0]         wait_nsec_o
);

  state_e           state_q, state_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             chk_q, chk_d;
  ts_t              now_q;
  logic             acc;
  ctl_t             ctl;
  ts_t              now_in, delay_in, head_dl;
  logic [MaskW-1:0] mask;
  ts_t              wt;

  logic [TimerCount-1:0] vld;
  ts_t                   dl  [TimerCount];
  ts_t                   per [TimerCount];
  logic                  wr_vld;
  ts_t                   wr_dl, wr_per;
  ts_t                   sel_per;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign now_in     = '{s: now_sec_i, ns: clamp_ns(now_nsec_i)};
  assign delay_in   = '{s: delay_sec_i, ns: clamp_ns(delay_nsec_i)};
  assign sel_per    = per[slot_i];

  // write data for add or retime
  always_comb begin
    wr_vld = 1'b1;
    wr_per = delay_in;
    wr_dl  = ts_add(now_in, delay_in);
    if (op_i == OP_RETIME) begin
      wr_vld = vld[slot_i];
      wr_per = sel_per;
      wr_dl  = vld[slot_i] ? ts_add(now_in, sel_per) : dl[slot_i];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    ctl     = '0;
    ctl.slot = slot_i;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cnt_d = '0;
          chk_d = (op_i == OP_CHECK);
          ctl.wr  = (op_i == OP_ADD) || (op_i == OP_RETIME);
          ctl.clr = (op_i == OP_REMOVE);
          state_d = (op_i == OP_CHECK) ? ST_RUN : ST_OUT;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == SlotW'(TimerCount - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) now_q <= now_in;
  end

  // row: cell i takes from cell i+1, last cell takes processed head entry
  for (genvar i = 0; i < TimerCount; i++) begin : g_cell
    logic nb_vld;
    ts_t  nb_dl, nb_per;
    if (i == TimerCount - 1) begin : g_tail
      assign nb_vld = vld[0];
      assign nb_dl  = head_dl;
      assign nb_per = per[0];
    end else begin : g_mid
      assign nb_vld = vld[i+1];
      assign nb_dl  = dl[i+1];
      assign nb_per = per[i+1];
    end
    ptt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .idx_i    (SlotW'(i)),
      .wr_vld_i (wr_vld),
      .wr_dl_i  (wr_dl),
      .wr_per_i (wr_per),
      .nb_vld_i (nb_vld),
      .nb_dl_i  (nb_dl),
      .nb_per_i (nb_per),
      .vld_o    (vld[i]),
      .dl_o     (dl[i]),
      .per_o    (per[i])
    );
  end

  ptt_proc u_proc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc),
    .step_i  (ctl.step),
    .cnt_i   (cnt_q),
    .now_i   (now_q),
    .vld_i   (vld[0]),
    .dl_i    (dl[0]),
    .per_i   (per[0]),
    .dl_o    (head_dl),
    .mask_o  (mask),
    .wait_o  (wt)
  );

  assign out_valid_o  = (state_q == ST_OUT);
  assign fired_mask_o = chk_q ? mask : '0;
  assign wait_sec_o   = chk_q ? wt.s : '0;
  assign wait_nsec_o  = chk_q ? wt.ns : '0;

endmodule

`default_nettype wire

[rtl/ptt_cell.sv]
// ----------------------------------------------------------------------------
// ptt_cell
// one timer entry; in a check pass the row rotates and the head cell's
// entry is processed and handed on
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_cell
  import ptt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctl_t             ctl_i,
  input  wire logic [SlotW-1:0] idx_i,
  input  wire logic             wr_vld_i,
  input  wire ts_t              wr_dl_i,
  input  wire ts_t              wr_per_i,
  input  wire logic             nb_vld_i,
  input  wire ts_t              nb_dl_i,
  input  wire ts_t              nb_per_i,
  output logic                  vld_o,
  output ts_t                   dl_o,
  output ts_t                   per_o
);

  logic vld_q, vld_d;
  ts_t  dl_q, dl_d, per_q, per_d;
  logic sel;

  assign sel = (ctl_i.slot == idx_i);

  always_comb begin
    vld_d = vld_q;
    dl_d  = dl_q;
    per_d = per_q;
    if (ctl_i.step) begin
      vld_d = nb_vld_i;
      dl_d  = nb_dl_i;
      per_d = nb_per_i;
    end else if (ctl_i.wr && sel) begin
      vld_d = wr_vld_i;
      dl_d  = wr_dl_i;
      per_d = wr_per_i;
    end else if (ctl_i.clr && sel) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q  <= dl_d;
    per_q <= per_d;
  end

  assign vld_o = vld_q;
  assign dl_o  = dl_q;
  assign per_o = per_q;

endmodule

`default_nettype wire

[rtl/ptt_proc.sv]
// ----------------------------------------------------------------------------
// ptt_proc
// head processing for the row: fire test, deadline advance, wait minimum
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_proc
  import ptt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             step_i,
  input  wire logic [SlotW-1:0] cnt_i,
  input  wire ts_t              now_i,
  input  wire logic             vld_i,
  input  wire ts_t              dl_i,
  input  wire ts_t              per_i,
  output ts_t                   dl_o,
  output logic [MaskW-1:0]      mask_o,
  output ts_t                   wait_o
);

  logic             fire;
  ts_t              wt;
  logic [MaskW-1:0] mask_q, mask_d;
  ts_t              wait_q, wait_d;

  assign fire = vld_i && !ts_lt(now_i, dl_i);
  assign dl_o = fire ? ts_add(dl_i, per_i) : dl_i;
  assign wt   = ts_sub(dl_o, now_i);

  always_comb begin
    mask_d = mask_q;
    wait_d = wait_q;
    if (start_i) begin
      mask_d = '0;
      wait_d = '{s: SecMax, ns: NsMax};
    end else if (step_i) begin
      if (fire) mask_d[cnt_i] = 1'b1;
      if (vld_i && ts_lt(wt, wait_q)) wait_d = wt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wait_q <= wait_d;
  end

  assign mask_o = mask_q;
  assign wait_o = wait_q;

endmodule

`default_nettype wire

[rtl/ptt_checker.sv]
// ----------------------------------------------------------------------------
// ptt_checker
// port-level checks on the timer table handshakes and results
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_timer_table_top_macros.svh"

module ptt_checker
  import ptt_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [MaskW-1:0] fired_mask_o,
  input wire logic [SecW-1:0]  wait_sec_o,
  input wire logic [NsW-1:0]   wait_nsec_o
);

  // one transaction in flight: no input taken while a result waits
  `PTT_ASSERT(a_no_overlap, clk_i, rst_ni, !(out_valid_o && in_ready_o),
    "input ready while result pending")
  // an accepted input leaves the block busy
  `PTT_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
    "ready stayed high after accept")
  `PTT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(fired_mask_o) && $stable(wait_sec_o) && $stable(wait_nsec_o),
    "result changed while stalled")
  `PTT_ASSERT(a_ns_range, clk_i, rst_ni, !out_valid_o || wait_nsec_o <= NsMax,
    "wait nanoseconds out of range")

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .fired_mask_o (fired_mask_o),
  .wait_sec_o   (wait_sec_o),
  .wait_nsec_o  (wait_nsec_o)
);

`default_nettype wire

[tb/tb_periodic_timer_table_top.sv]
// ----------------------------------------------------------------------------
// tb_periodic_timer_table_top
// drives add, remove, retime and check transactions into the timer table and
// compares each result against a cycle-free predictor of the sixteen timers
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_periodic_timer_table_top;
  import ptt_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct {
    logic [MaskW-1:0] mask;
    logic [SecW-1:0]  wsec;
    logic [NsW-1:0]   wns;
  } wait_res_t;

  typedef struct {
    longint s;
    int     ns;
  } tm_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       op_i = '0;
  logic [SlotW-1:0] slot_i = '0;
  logic [SecW-1:0]  delay_sec_i = '0;
  logic [NsW-1:0]   delay_nsec_i = '0;
  logic [SecW-1:0]  now_sec_i = '0;
  logic [NsW-1:0]   now_nsec_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [MaskW-1:0] fired_mask_o;
  logic [SecW-1:0]  wait_sec_o;
  logic [NsW-1:0]   wait_nsec_o;

  periodic_timer_table_top DUT (.*);

  // predicted timer state
  bit        tmr_on [TimerCount];
  tm_t       tmr_dl [TimerCount];
  tm_t       tmr_per[TimerCount];
  wait_res_t pending_q[$];
  int        err_cnt = 0;
  int        idle_cyc = 0;
  int        ready_hold = 0;
  bit        stall_mode = 0;

  initial forever #10 clk_i = ~clk_i;

  function automatic tm_t tm_max();
    tm_t r;
    r.s = 64'sh7fff_ffff_ffff_ffff; r.ns = 999999999;
    return r;
  endfunction

  function automatic tm_t tm_min();
    tm_t r;
    r.s = 64'sh8000_0000_0000_0000; r.ns = 0;
    return r;
  endfunction

  // 66-bit wide sums make saturation a range check
  function automatic tm_t tm_sum(tm_t a, tm_t b);
    tm_t r;
    int n;
    logic signed [65:0] s;
    n = a.ns + b.ns;
    s = 66'(signed'(a.s)) + 66'(signed'(b.s));
    if (n >= 1000000000) begin
      n -= 1000000000; s += 1;
    end
    if (s > 66'sh0_7fff_ffff_ffff_ffff) return tm_max();
    if (s < -66'sh0_8000_0000_0000_0000) return tm_min();
    r.s = longint'(s); r.ns = n;
    return r;
  endfunction

  function automatic tm_t tm_diff(tm_t a, tm_t b);
    tm_t r;
    int n;
    logic signed [65:0] s;
    n = a.ns - b.ns;
    s = 66'(signed'(a.s)) - 66'(signed'(b.s));
    if (n < 0) begin
      n += 1000000000; s -= 1;
    end
    if (s > 66'sh0_7fff_ffff_ffff_ffff) return tm_max();
    if (s < -66'sh0_8000_0000_0000_0000) return tm_min();
    r.s = longint'(s); r.ns = n;
    return r;
  endfunction

  function automatic bit tm_less(tm_t a, tm_t b);
    if (a.s != b.s) return a.s < b.s;
    return a.ns < b.ns;
  endfunction

  function automatic int ns_sat(logic [NsW-1:0] v);
    return (v > 30'd999999999) ? 999999999 : int'(v);
  endfunction

  function automatic wait_res_t timers_apply(op_e op, int slot, tm_t dly, tm_t now);
    wait_res_t r;
    tm_t best, t;
    r = '{default: '0};
    case (op)
      OP_ADD: begin
        tmr_per[slot] = dly; tmr_dl[slot] = tm_sum(now, dly); tmr_on[slot] = 1;
      end
      OP_REMOVE: tmr_on[slot] = 0;
      OP_RETIME: if (tmr_on[slot]) tmr_dl[slot] = tm_sum(now, tmr_per[slot]);
      OP_CHECK: begin
        best = tm_max();
        for (int i = 0; i < TimerCount; i++) begin
          if (!tmr_on[i]) continue;
          if (!tm_less(now, tmr_dl[i])) begin
            tmr_dl[i] = tm_sum(tmr_dl[i], tmr_per[i]);
            r.mask[i] = 1'b1;
          end
          t = tm_diff(tmr_dl[i], now);
          if (tm_less(t, best)) best = t;
        end
        r.wsec = best.s; r.wns = NsW'(best.ns);
      end
      default: ;
    endcase
    return r;
  endfunction

  // valid drops only when a real gap follows
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_op(op_e op, int slot, logic [63:0] ds, logic [NsW-1:0] dn,
                         logic [63:0] ns, logic [NsW-1:0] nn, bit gaps = 1);
    tm_t dly, now;
    if (gaps) idle_gap();
    dly.s = ds; dly.ns = ns_sat(dn);
    now.s = ns; now.ns = ns_sat(nn);
    in_valid_i   <= 1'b1;
    op_i         <= op;
    slot_i       <= slot[SlotW-1:0];
    delay_sec_i  <= ds;
    delay_nsec_i <= dn;
    now_sec_i    <= ns;
    now_nsec_i   <= nn;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(timers_apply(op, slot, dly, now));
  endtask

  function automatic logic [63:0] rnd_sec();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'h7fff_ffff_ffff_fff0 + $urandom_range(0, 15);
      2: return 64'h8000_0000_0000_0000 + $urandom_range(0, 15);
      default: return 64'(signed'($urandom_range(0, 40) - 20));
    endcase
  endfunction

  function automatic logic [NsW-1:0] rnd_ns();
    case ($urandom_range(0, 5))
      0: return 30'($urandom);
      1: return 30'(999999999 - $urandom_range(0, 3));
      2: return 30'($urandom_range(0, 3));
      default: return 30'($urandom_range(0, 999999999));
    endcase
  endfunction

  task automatic test_directed();
    logic [63:0] mx, mn;
    mx = SecMax; mn = SecMin;
    send_op(OP_CHECK, 0, 0, 0, 0, 0);                     // empty table
    send_op(OP_ADD, 0, 1, 999999999, 0, 999999999);       // nsec carry
    send_op(OP_ADD, 15, mx, 999999999, mx, 999999999);    // saturate high
    send_op(OP_ADD, 7, mn, 0, mn, 0);                     // saturate low
    send_op(OP_ADD, 3, 2, 30'h3fff_ffff, 5, 30'h3fff_ffff); // clamp nsec
    send_op(OP_CHECK, 0, 0, 0, 1, 999999999);
    send_op(OP_RETIME, 3, 0, 0, 100, 5);
    send_op(OP_RETIME, 9, 0, 0, 100, 5);                  // invalid entry
    send_op(OP_REMOVE, 9, 0, 0, 0, 0);                    // invalid entry
    send_op(OP_ADD, 0, 0, 0, 10, 0);                      // overwrite, zero period
    send_op(OP_CHECK, 0, 0, 0, 10, 0);
    send_op(OP_CHECK, 0, 0, 0, mn, 0);
    send_op(OP_CHECK, 0, 0, 0, mx, 999999999);
    send_op(OP_ADD, 1, mn, 0, mx, 999999999);
    send_op(OP_CHECK, 0, 0, 0, mx, 999999999);
    for (int i = 0; i < TimerCount; i++) send_op(OP_REMOVE, i, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [63:0] clk_s;
    op_e op;
    clk_s = 0;
    for (int k = 0; k < count; k++) begin
      stall_mode = (k % 300) >= 200;
      if ($urandom_range(0, 7) == 0) begin
        op = op_e'($urandom_range(0, 3));
        send_op(op, $urandom_range(0, 15), rnd_sec(), rnd_ns(), rnd_sec(), rnd_ns(),
                !stall_mode);
      end else begin
        // realistic timeline: small periods, time advancing
        clk_s += 64'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0, 1, 2: send_op(OP_ADD, $urandom_range(0, 15), 64'($urandom_range(0, 5)),
                           30'($urandom_range(0, 999999999)), clk_s,
                           30'($urandom_range(0, 999999999)), !stall_mode);
          3: send_op(OP_REMOVE, $urandom_range(0, 15), 0, 0, 0, 0, !stall_mode);
          4: send_op(OP_RETIME, $urandom_range(0, 15), 0, 0, clk_s,
                     30'($urandom_range(0, 999999999)), !stall_mode);
          default: send_op(OP_CHECK, $urandom_range(0, 15), 0, 0, clk_s,
                           30'($urandom_range(0, 999999999)), !stall_mode);
        endcase
      end
    end
  endtask

  // result side: random back-pressure, checks against oldest prediction
  always @(posedge clk_i) begin
    wait_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (fired_mask_o !== e.mask) begin
          $error("fired_mask exp %h got %h", e.mask, fired_mask_o); err_cnt++;
        end
        if (wait_sec_o !== e.wsec) begin
          $error("wait_sec exp %0d got %0d", $signed(e.wsec), $signed(wait_sec_o));
          err_cnt++;
        end
        if (wait_nsec_o !== e.wns) begin
          $error("wait_nsec exp %0d got %0d", e.wns, wait_nsec_o); err_cnt++;
        end
      end
    end
    if (stall_mode) out_ready_i <= 1'b1;
    else if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      // occasional long stall
      ready_hold  <= $urandom_range(5, 40);
      out_ready_i <= 1'b0;
    end
    else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 2) != 0) out_ready_i <= 1'b1;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WatchLimit) begin
      $display("tb_periodic_timer_table_top: done, errors");
      $finish;
    end
  end

  initial begin
    int guard;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1330);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_q.size() != 0 && guard < WatchLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0)
      $display("tb_periodic_timer_table_top: done, clean");
    else
      $display("tb_periodic_timer_table_top: done, errors");
    $finish;
  end

endmodule

[periodic_timer_table_top.f]
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_cell.sv
rtl/ptt_proc.sv
rtl/periodic_timer_table_top.sv
rtl/ptt_checker.sv
tb/tb_periodic_timer_table_top.sv
